// ===== design/iup_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iup_pkg
// Shared types and constants of the integer-factor image upscaler.
// ----------------------------------------------------------------------------
package iup_pkg;

  localparam int COORD_BITS    = 13;
  localparam int OUT_PIX_BITS  = 16;
  localparam int CNT_BITS      = 11;
  localparam int SF_BITS       = 4;
  localparam int CFG_DATA_BITS = 11;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERP_MODE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_FACTOR  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_HEIGHT = 2'd3;

  localparam logic                RST_INTERP_MODE   = 1'b1;
  localparam logic [SF_BITS-1:0]  RST_SCALE_FACTOR  = 4'd2;
  localparam logic [CNT_BITS-1:0] RST_SOURCE_WIDTH  = 11'd1024;
  localparam logic [CNT_BITS-1:0] RST_SOURCE_HEIGHT = 11'd1024;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_UPD  = 3'b010,
    ST_GEN  = 3'b100
  } iup_state_t;

  // one output pixel slot travelling down the datapath
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
  } iup_issue_t;

endpackage

// ===== design/iup_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iup_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module iup_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/iup_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iup_ctrl
// Input sequencer: line store read/modify/write, source counters, cell
// corners and the per-block output pixel generator.
// ----------------------------------------------------------------------------
module iup_ctrl import iup_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 8,
  parameter int PIXEL_BITS = 16,
  localparam int FB = $clog2(MAX_FACTOR + 1),
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] pixel_in,
  input  logic [FB-1:0]         f,
  input  logic [CNT_BITS-1:0]   w,
  input  logic [CNT_BITS-1:0]   h,
  input  logic                  adv,
  output logic [FB-1:0]         i,
  output logic [FB-1:0]         j,
  output iup_issue_t            issue,
  output logic [PIXEL_BITS-1:0] c_ul,
  output logic [PIXEL_BITS-1:0] c_ur,
  output logic [PIXEL_BITS-1:0] c_ll,
  output logic [PIXEL_BITS-1:0] c_lr
);

  iup_state_t state;

  logic [PIXEL_BITS-1:0]    pix;
  logic [PIXEL_BITS-1:0]    left_pix;
  logic [PIXEL_BITS-1:0]    ul_pix;
  logic [PIXEL_BITS-1:0]    ram_rdata;
  logic [CNT_BITS-1:0]      col_cnt;
  logic [CNT_BITS-1:0]      row_cnt;
  logic [CNT_BITS:0]        col_inc;
  logic [CNT_BITS:0]        row_inc;
  logic [CNT_BITS+FB-1:0]   rprod;
  logic [CNT_BITS+FB-1:0]   cprod;
  logic [COORD_BITS-1:0]    rbase;
  logic [COORD_BITS-1:0]    cbase;
  logic [AW-1:0]            idx;
  logic                     has_block;
  logic                     i_last;
  logic                     j_last;

  assign in_stall  = (state != ST_IDLE);
  assign idx       = (32'(col_cnt) < MAX_WIDTH) ? AW'(col_cnt) : AW'(MAX_WIDTH - 1);
  assign col_inc   = {1'b0, col_cnt} + 12'd1;
  assign row_inc   = {1'b0, row_cnt} + 12'd1;
  assign rprod     = (row_cnt - 11'd1) * f;
  assign cprod     = (col_cnt - 11'd1) * f;
  assign has_block = (row_cnt != '0) && (col_cnt != '0);
  assign i_last    = (i == f - FB'(1));
  assign j_last    = (j == f - FB'(1));

  assign issue.valid = (state == ST_GEN);
  assign issue.last  = i_last && j_last;
  assign issue.row   = rbase + COORD_BITS'(i);
  assign issue.col   = cbase + COORD_BITS'(j);

  iup_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (state == ST_UPD),
    .waddr (idx),
    .wdata (pix),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      col_cnt  <= '0;
      row_cnt  <= '0;
      left_pix <= '0;
      ul_pix   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            pix   <= pixel_in;
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          c_ul     <= ul_pix;
          c_ur     <= ram_rdata;
          c_ll     <= left_pix;
          c_lr     <= pix;
          ul_pix   <= ram_rdata;
          left_pix <= pix;
          rbase    <= COORD_BITS'(rprod);
          cbase    <= COORD_BITS'(cprod);
          i        <= '0;
          j        <= '0;
          if (col_inc >= {1'b0, w}) begin
            col_cnt <= '0;
            row_cnt <= (row_inc >= {1'b0, h}) ? '0 : CNT_BITS'(row_inc);
          end else begin
            col_cnt <= CNT_BITS'(col_inc);
          end
          state <= has_block ? ST_GEN : ST_IDLE;
        end
        ST_GEN: begin
          if (adv) begin
            if (j_last) begin
              j <= '0;
              if (i_last) begin
                state <= ST_IDLE;
              end else begin
                i <= i + FB'(1);
              end
            end else begin
              j <= j + FB'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_upd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> (state == ST_UPD))
    else $error("accepted transfer did not start line store update");

  a_upd_once: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |=> (state != ST_UPD))
    else $error("line store update longer than one cycle");

  a_gen_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GEN) |-> (i < f) && (j < f))
    else $error("block offset out of range");

endmodule

// ===== design/iup_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iup_interp
// Interpolation pipeline: corner weights, products, rounded sum and a
// pipelined restoring divide by 2*f*f, then the output register.
// ----------------------------------------------------------------------------
module iup_interp import iup_pkg::*; #(
  parameter int MAX_FACTOR = 8,
  parameter int PIXEL_BITS = 16,
  localparam int FB = $clog2(MAX_FACTOR + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    interp_mode,
  input  logic [FB-1:0]           f,
  input  logic [FB-1:0]           i,
  input  logic [FB-1:0]           j,
  input  iup_issue_t              issue,
  input  logic [PIXEL_BITS-1:0]   c_ul,
  input  logic [PIXEL_BITS-1:0]   c_ur,
  input  logic [PIXEL_BITS-1:0]   c_ll,
  input  logic [PIXEL_BITS-1:0]   c_lr,
  output logic                    adv,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUT_PIX_BITS-1:0] pixel_out,
  output logic [COORD_BITS-1:0]   out_row,
  output logic [COORD_BITS-1:0]   out_col,
  output logic                    block_last
);

  localparam int PB = PIXEL_BITS;
  localparam int WB = 2 * FB;
  localparam int DB = WB + 1;
  localparam int PW = PB + WB;
  localparam int NB = PB + DB;

  logic [FB-1:0]   fi;
  logic [FB-1:0]   fj;
  logic            lower;
  logic            right;
  logic [WB-1:0]   ff;
  logic [DB-1:0]   dvsr;

  iup_issue_t      s1;
  logic [WB-1:0]   w_ul, w_ur, w_ll, w_lr;
  logic [PB-1:0]   near1;
  // corners travel with the slot; the sequencer may load the next cell early
  logic [PB-1:0]   s1_ul, s1_ur, s1_ll, s1_lr;

  iup_issue_t      s2;
  logic [PW-1:0]   p_ul, p_ur, p_ll, p_lr;
  logic [PB-1:0]   near2;
  logic [PW-1:0]   s_sum;
  logic [NB-1:0]   n_val;

  iup_issue_t      ds    [0:PB];
  logic [DB-1:0]   drem  [0:PB];
  logic [PB-1:0]   dlo   [0:PB];
  logic [PB-1:0]   dnear [0:PB];

  assign adv   = !out_valid || !out_stall;
  assign fi    = f - i;
  assign fj    = f - j;
  assign lower = ({i, 1'b0} >= {1'b0, f});
  assign right = ({j, 1'b0} >= {1'b0, f});
  assign ff    = f * f;
  assign dvsr  = {ff, 1'b0};
  assign s_sum = p_ul + p_ur + p_ll + p_lr;
  assign n_val = {s_sum, 1'b0} + NB'(ff);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid    <= 1'b0;
      s2.valid    <= 1'b0;
      ds[0].valid <= 1'b0;
    end else if (adv) begin
      s1    <= issue;
      w_ul  <= fi * fj;
      w_ur  <= j * fi;
      w_ll  <= i * fj;
      w_lr  <= i * j;
      near1 <= lower ? (right ? c_lr : c_ll) : (right ? c_ur : c_ul);
      s1_ul <= c_ul;
      s1_ur <= c_ur;
      s1_ll <= c_ll;
      s1_lr <= c_lr;

      s2    <= s1;
      p_ul  <= w_ul * s1_ul;
      p_ur  <= w_ur * s1_ur;
      p_ll  <= w_ll * s1_ll;
      p_lr  <= w_lr * s1_lr;
      near2 <= near1;

      ds[0]    <= s2;
      drem[0]  <= n_val[NB-1:PB];
      dlo[0]   <= n_val[PB-1:0];
      dnear[0] <= near2;
    end
  end

  for (genvar k = 1; k <= PB; k++) begin : g_div
    logic [DB:0] t;
    logic        ge;
    assign t  = {drem[k-1], dlo[k-1][PB-1]};
    assign ge = (t >= {1'b0, dvsr});
    always_ff @(posedge clk) begin
      if (rst) begin
        ds[k].valid <= 1'b0;
      end else if (adv) begin
        ds[k]    <= ds[k-1];
        drem[k]  <= ge ? DB'(t - {1'b0, dvsr}) : DB'(t);
        dlo[k]   <= {dlo[k-1][PB-2:0], ge};
        dnear[k] <= dnear[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid  <= ds[PB].valid;
      pixel_out  <= interp_mode ? OUT_PIX_BITS'(dlo[PB]) : OUT_PIX_BITS'(dnear[PB]);
      out_row    <= ds[PB].row;
      out_col    <= ds[PB].col;
      block_last <= ds[PB].last;
    end
  end

  a_rem_init: assert property (@(posedge clk) disable iff (rst)
    ds[0].valid |-> (drem[0] < dvsr))
    else $error("weighted sum exceeds quotient range");

  a_rem_final: assert property (@(posedge clk) disable iff (rst)
    ds[PB].valid |-> (drem[PB] < dvsr))
    else $error("divider remainder not reduced");

endmodule

// ===== design/image_upscale_integer_factor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_upscale_integer_factor_top
// Integer-factor image upscaler, bilinear or nearest neighbour.
//
// Source pixels enter on in_valid/in_stall/pixel_in in raster order. Each
// transfer at source row r >= 1 and column c >= 1 yields the f-by-f output
// block of the cell spanned by (r-1,c-1) and (r,c), row-major, on
// out_valid/out_stall with out_row, out_col and block_last on the block's
// final pixel. Pixels of the first row or column produce no output.
// A transfer reads the line store, then writes it back and updates the
// counters, then generates its block at one pixel per cycle while out_stall
// does not freeze the generator; first row/column pixels skip generation.
// The rate is set by the single block generator and the line store
// read/write turn. Pixels pass weight, product, rounding, bit-per-stage
// divider and output register stages. out_stall with out_valid high
// freezes the interpolation pipeline and the generator; in_stall is high
// whenever an input is in progress. Reset clears counters, neighbor pixels
// and pipeline valids and restores the default configuration, not the line
// store. Configuration is written through cfg_wr_en/cfg_index/cfg_data;
// the user must do so only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module image_upscale_integer_factor_top import iup_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PIXEL_BITS-1:0]    pixel_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OUT_PIX_BITS-1:0]  pixel_out,
  output logic [COORD_BITS-1:0]    out_row,
  output logic [COORD_BITS-1:0]    out_col,
  output logic                     block_last
);

  localparam int FB = $clog2(MAX_FACTOR + 1);

  logic                  interp_mode;
  logic [SF_BITS-1:0]    scale_factor;
  logic [CNT_BITS-1:0]   source_width;
  logic [CNT_BITS-1:0]   source_height;

  logic [FB-1:0]         f_eff;
  logic [CNT_BITS-1:0]   w_eff;
  logic [CNT_BITS-1:0]   h_eff;
  logic                  adv;
  logic [FB-1:0]         gi;
  logic [FB-1:0]         gj;
  iup_issue_t            issue;
  logic [PIXEL_BITS-1:0] c_ul, c_ur, c_ll, c_lr;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode   <= RST_INTERP_MODE;
      scale_factor  <= RST_SCALE_FACTOR;
      source_width  <= RST_SOURCE_WIDTH;
      source_height <= RST_SOURCE_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_INTERP_MODE:   interp_mode   <= cfg_data[0];
        CFG_SCALE_FACTOR:  scale_factor  <= cfg_data[SF_BITS-1:0];
        CFG_SOURCE_WIDTH:  source_width  <= cfg_data;
        CFG_SOURCE_HEIGHT: source_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (scale_factor == '0) begin
      f_eff = FB'(1);
    end else if (32'(scale_factor) > MAX_FACTOR) begin
      f_eff = FB'(MAX_FACTOR);
    end else begin
      f_eff = FB'(scale_factor);
    end

    if (source_width < 11'd2) begin
      w_eff = 11'd2;
    end else if (32'(source_width) > MAX_WIDTH) begin
      w_eff = CNT_BITS'(MAX_WIDTH);
    end else begin
      w_eff = source_width;
    end

    h_eff = (source_height < 11'd2) ? 11'd2 : source_height;
  end

  iup_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pixel_in (pixel_in),
    .f        (f_eff),
    .w        (w_eff),
    .h        (h_eff),
    .adv      (adv),
    .i        (gi),
    .j        (gj),
    .issue    (issue),
    .c_ul     (c_ul),
    .c_ur     (c_ur),
    .c_ll     (c_ll),
    .c_lr     (c_lr)
  );

  iup_interp #(
    .MAX_FACTOR (MAX_FACTOR),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_interp (
    .clk         (clk),
    .rst         (rst),
    .interp_mode (interp_mode),
    .f           (f_eff),
    .i           (gi),
    .j           (gj),
    .issue       (issue),
    .c_ul        (c_ul),
    .c_ur        (c_ur),
    .c_ll        (c_ll),
    .c_lr        (c_lr),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .out_row     (out_row),
    .out_col     (out_col),
    .block_last  (block_last)
  );

endmodule

// ===== dv/tb_image_upscale_integer_factor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_upscale_integer_factor_top
// Self-checking bench for the integer-factor image upscaler.
//
// Source pixels stream in raster order. An in-bench model of the line store,
// the neighbor pixels and the row/column counters predicts every output pixel
// with its coordinates and block_last flag. Each output transfer is checked
// against the oldest prediction. A directed table covers the extreme samples,
// both interpolation modes and out-of-range register values. Random frames
// follow, with sizes reduced mid-frame and a long output hold-off. Both
// handshakes idle in random bursts, except in the hold-off and closing phases.
// ----------------------------------------------------------------------------
module tb_image_upscale_integer_factor_top;
  import iup_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_FACTOR    = 8;
  localparam int PIXEL_BITS    = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 500;
  localparam int RANDOM_PIXELS = 150;

  typedef enum bit {ROW_PIXEL, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [10:0]        mode;
    logic [10:0]        factor;
    logic [10:0]        width;
    logic [10:0]        height;
    logic [15:0]        px;
    logic               pinned;
    logic [15:0]        pin_px;
  } stim_row_t;

  typedef struct packed {
    logic [OUT_PIX_BITS-1:0] pix;
    logic [COORD_BITS-1:0]   row;
    logic [COORD_BITS-1:0]   col;
    logic                    last;
  } out_pixel_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [PIXEL_BITS-1:0]    pixel_in;
  logic                     out_valid;
  logic                     out_stall;
  logic [OUT_PIX_BITS-1:0]  pixel_out;
  logic [COORD_BITS-1:0]    out_row;
  logic [COORD_BITS-1:0]    out_col;
  logic                     block_last;

  // model state
  logic [15:0]              line_store [0:MAX_WIDTH-1];
  logic [15:0]              left_px;
  logic [15:0]              up_left_px;
  int unsigned              col_cnt;
  int unsigned              row_cnt;
  logic                     mode_r;
  logic [SF_BITS-1:0]       factor_r;
  logic [CNT_BITS-1:0]      width_r;
  logic [CNT_BITS-1:0]      height_r;

  out_pixel_t               expected_block_pixels [$];
  int                       mismatch_count;
  int                       pixels_sent;
  int                       stall_pct;
  int                       in_gap_pct;
  bit                       hold_off_req;
  stim_row_t                directed_tab [0:28];

  image_upscale_integer_factor_top #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR),
    .PIXEL_BITS (PIXEL_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .out_row    (out_row),
    .out_col    (out_col),
    .block_last (block_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic stim_row_t cfg_row(input logic [10:0] mode, input logic [10:0] factor,
                                        input logic [10:0] width, input logic [10:0] height);
    stim_row_t r;
    r = '0;
    r.kind   = ROW_CONFIG;
    r.mode   = mode;
    r.factor = factor;
    r.width  = width;
    r.height = height;
    return r;
  endfunction

  function automatic stim_row_t pix_row(input logic [15:0] px);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PIXEL;
    r.px   = px;
    return r;
  endfunction

  // every pixel of the block this transfer completes must equal val
  function automatic stim_row_t pin_row(input logic [15:0] px, input logic [15:0] val);
    stim_row_t r;
    r = pix_row(px);
    r.pinned = 1'b1;
    r.pin_px = val;
    return r;
  endfunction

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic predict_upscaled_block(input logic [15:0] px, input logic pinned,
                                        input logic [15:0] pin_px);
    int unsigned f, w, h, col, row, idx, ff, s, v, i, j;
    logic [15:0] above;
    out_pixel_t  r;
    f   = (factor_r == 0) ? 1 : ((factor_r > MAX_FACTOR) ? MAX_FACTOR : factor_r);
    w   = (width_r < 2) ? 2 : ((width_r > MAX_WIDTH) ? MAX_WIDTH : width_r);
    h   = (height_r < 2) ? 2 : height_r;
    col = col_cnt;
    row = row_cnt;
    idx = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
    above = line_store[idx];
    if (row >= 1 && col >= 1) begin
      ff = f * f;
      for (i = 0; i < f; i++) begin
        for (j = 0; j < f; j++) begin
          if (mode_r) begin
            s = (f - i) * (f - j) * up_left_px + j * (f - i) * above
              + i * (f - j) * left_px + i * j * px;
            v = (2 * s + ff) / (2 * ff);
          end else if (2 * i >= f) begin
            v = (2 * j >= f) ? px : left_px;
          end else begin
            v = (2 * j >= f) ? above : up_left_px;
          end
          r.pix  = pinned ? pin_px : v[15:0];
          r.row  = COORD_BITS'((row - 1) * f + i);
          r.col  = COORD_BITS'((col - 1) * f + j);
          r.last = (i == f - 1) && (j == f - 1);
          expected_block_pixels.push_back(r);
        end
      end
    end
    up_left_px      = above;
    line_store[idx] = px;
    left_px         = px;
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_INTERP_MODE:   mode_r   = data[0];
      CFG_SCALE_FACTOR:  factor_r = data[SF_BITS-1:0];
      CFG_SOURCE_WIDTH:  width_r  = data;
      CFG_SOURCE_HEIGHT: height_r = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [10:0] mode, input logic [10:0] factor,
                            input logic [10:0] width, input logic [10:0] height);
    write_reg(CFG_INTERP_MODE, mode);
    write_reg(CFG_SCALE_FACTOR, factor);
    write_reg(CFG_SOURCE_WIDTH, width);
    write_reg(CFG_SOURCE_HEIGHT, height);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_config();
    logic [10:0] f_raw, w_raw, h_raw;
    f_raw = ($urandom_range(0, 4) == 0) ? 11'($urandom) : 11'($urandom_range(1, 4));
    w_raw = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 1)) : 11'($urandom_range(2, 9));
    h_raw = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 1)) : 11'($urandom_range(2, 6));
    set_config(11'($urandom_range(0, 1)), f_raw, w_raw, h_raw);
  endtask

  task automatic drive_pixel(input logic [15:0] px, input logic pinned,
                             input logic [15:0] pin_px);
    in_valid <= 1'b1;
    pixel_in <= px;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_upscaled_block(px, pinned, pin_px);
    pixels_sent++;
    if ($urandom_range(1, 100) <= in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic stream_pixels(input int n_items, input bit to_frame_end);
    int sent;
    sent = 0;
    while (sent < n_items || (to_frame_end && (col_cnt != 0 || row_cnt != 0))) begin
      drive_pixel(random_sample(), 1'b0, 16'h0000);
      sent++;
    end
  endtask

  // block idle: nothing pending and the pipeline flushed
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_block_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_pixel_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_block_pixels.size() == 0) begin
        $display("%0t: unexpected transfer pixel_out %0d row %0d col %0d last %0d",
                 $time, pixel_out, out_row, out_col, block_last);
        mismatch_count++;
      end else begin
        want = expected_block_pixels.pop_front();
        if (pixel_out !== want.pix)   report_field("pixel_out", want.pix, pixel_out);
        if (out_row !== want.row)     report_field("out_row", want.row, out_row);
        if (out_col !== want.col)     report_field("out_col", want.col, out_col);
        if (block_last !== want.last) report_field("block_last", want.last, block_last);
      end
    end
  end

  // output stall: random bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(1, 100) <= stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        if (stall_pct != 0) repeat ($urandom_range(0, 14)) @(posedge clk);
      end
    end
  end

  initial begin
    int random_start;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_INTERP_MODE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    pixel_in       = '0;
    mismatch_count = 0;
    pixels_sent    = 0;
    stall_pct      = 0;
    in_gap_pct     = 0;
    hold_off_req   = 1'b0;
    mode_r         = RST_INTERP_MODE;
    factor_r       = RST_SCALE_FACTOR;
    width_r        = RST_SOURCE_WIDTH;
    height_r       = RST_SOURCE_HEIGHT;
    left_px        = '0;
    up_left_px     = '0;
    col_cnt        = 0;
    row_cnt        = 0;

    directed_tab = '{
      // factor 0, width 1, height 0 all clamp up: f=1 output is the upper-left
      cfg_row(11'd1, 11'd0, 11'd1, 11'd0),
      pix_row(16'h0000), pix_row(16'hFFFF), pix_row(16'hFFFF), pin_row(16'h0000, 16'h0000),
      // factor 15 clamps to 8; flat cells give flat blocks
      cfg_row(11'd1, 11'h7FF, 11'd2, 11'd2),
      pix_row(16'hFFFF), pix_row(16'hFFFF), pix_row(16'hFFFF), pin_row(16'hFFFF, 16'hFFFF),
      pix_row(16'h0000), pix_row(16'h0000), pix_row(16'h0000), pin_row(16'h0000, 16'h0000),
      // nearest, odd and even factor
      cfg_row(11'd0, 11'd3, 11'd2, 11'd2),
      pix_row(16'd1), pix_row(16'd2), pix_row(16'd3), pix_row(16'd4),
      cfg_row(11'd0, 11'd4, 11'd2, 11'd2),
      pix_row(16'hAAAA), pix_row(16'h5555), pix_row(16'h8000), pix_row(16'h7FFF),
      // bilinear halves round up
      cfg_row(11'd1, 11'd2, 11'd2, 11'd2),
      pix_row(16'h0000), pix_row(16'h0001), pix_row(16'hFFFF), pix_row(16'hFFFE)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    stall_pct  = 25;
    in_gap_pct = 25;
    foreach (directed_tab[k]) begin
      if (directed_tab[k].kind == ROW_CONFIG) begin
        drain_and_settle();
        set_config(directed_tab[k].mode, directed_tab[k].factor,
                   directed_tab[k].width, directed_tab[k].height);
      end else begin
        drive_pixel(directed_tab[k].px, directed_tab[k].pinned, directed_tab[k].pin_px);
      end
    end

    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      drain_and_settle();
      stall_pct  = 30 * $urandom_range(0, 2);
      in_gap_pct = 25 * $urandom_range(0, 2);
      random_config();
      stream_pixels($urandom_range(20, 40), 1'b1);
    end

    // shrink width and height while the counters sit past the new sizes
    drain_and_settle();
    set_config(11'($urandom_range(0, 1)), 11'd3, 11'd8, 11'd6);
    stream_pixels(29, 1'b0);
    drain_and_settle();
    set_config(11'($urandom_range(0, 1)), 11'd3, 11'd3, 11'd2);
    stream_pixels(0, 1'b1);

    // receiver holds off while the sender keeps offering
    drain_and_settle();
    stall_pct    = 0;
    in_gap_pct   = 0;
    set_config(11'd1, 11'd8, 11'd4, 11'd3);
    hold_off_req = 1'b1;
    stream_pixels(24, 1'b1);

    // closing phase without idling
    drain_and_settle();
    stall_pct  = 0;
    in_gap_pct = 0;
    random_config();
    stream_pixels(40, 1'b1);
    drain_and_settle();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
